// ===== rtl/core/mxm_pkg.sv =====
`default_nettype none
package mxm_pkg;

  localparam int unsigned DIM          = 4;
  localparam int unsigned ROW_W        = $clog2(DIM);
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned FRAC_BITS_DF = 16;
  localparam int unsigned WORD_BITS_DF = 32;
  // one (i, k) step per cycle over the whole product
  localparam int unsigned STEP_W       = 2 * ROW_W;

  typedef struct packed {
    logic signed [DATA_W-1:0] a_col0;
    logic signed [DATA_W-1:0] a_col1;
    logic signed [DATA_W-1:0] a_col2;
    logic signed [DATA_W-1:0] a_col3;
    logic signed [DATA_W-1:0] b_col0;
    logic signed [DATA_W-1:0] b_col1;
    logic signed [DATA_W-1:0] b_col2;
    logic signed [DATA_W-1:0] b_col3;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] c_col0;
    logic signed [DATA_W-1:0] c_col1;
    logic signed [DATA_W-1:0] c_col2;
    logic signed [DATA_W-1:0] c_col3;
    logic        [ROW_W-1:0]  row_number;
    logic                     last_row;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic             wr_en;   // store the incoming rows
    logic [ROW_W-1:0] wr_row;  // row slot for the write
    logic             rd_en;   // issue one (i, k) step
    logic [ROW_W-1:0] rd_i;    // product row
    logic [ROW_W-1:0] rd_k;    // inner index
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/mxm_ram.sv =====
`default_nettype none
module mxm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mxm_ctrl.sv =====
`default_nettype none
module mxm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output      logic          busy_o,
  output      mxm_pkg::cmd_t cmd_o
);

  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } state_e;

  localparam logic [mxm_pkg::ROW_W-1:0]  LAST_ROW  = mxm_pkg::ROW_W'(mxm_pkg::DIM - 1);
  localparam logic [mxm_pkg::STEP_W-1:0] LAST_STEP = '1;

  state_e                       state_q;
  logic [mxm_pkg::ROW_W-1:0]    rows_q;
  logic [mxm_pkg::STEP_W-1:0]   step_q;
  logic                         accept;

  assign accept = start_i && (state_q == ST_LOAD);
  assign busy_o = (state_q == ST_RUN);

  always_comb begin
    cmd_o.wr_en  = accept;
    cmd_o.wr_row = rows_q;
    cmd_o.rd_en  = (state_q == ST_RUN);
    cmd_o.rd_i   = step_q[mxm_pkg::STEP_W-1:mxm_pkg::ROW_W];
    cmd_o.rd_k   = step_q[mxm_pkg::ROW_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      rows_q  <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            rows_q <= rows_q + 1'b1;
            step_q <= '0;
            if (rows_q == LAST_ROW) begin
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          step_q <= step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            state_q <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mxm_dp.sv =====
`default_nettype none
module mxm_dp #(
  parameter int unsigned FRAC_BITS = mxm_pkg::FRAC_BITS_DF,
  parameter int unsigned WORD_BITS = mxm_pkg::WORD_BITS_DF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mxm_pkg::cmd_t cmd_i,
  input  wire mxm_pkg::in_t  in_i,
  output      logic          valid_o,
  output      mxm_pkg::out_t out_o
);

  localparam int unsigned W      = WORD_BITS;
  localparam int unsigned N      = mxm_pkg::DIM;
  localparam int unsigned RW     = mxm_pkg::ROW_W;
  localparam int unsigned PROD_W = 2 * W;
  localparam int unsigned ACC_W  = PROD_W + RW;

  localparam logic signed [W-1:0]  MAX_V    = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  MIN_V    = {1'b1, {(W-1){1'b0}}};
  localparam logic [RW-1:0]        LAST_IDX = RW'(N - 1);

  logic [N*W-1:0] a_wdata, b_wdata, a_row, b_row;

  // stage 1: rows out of the stores
  logic          v1_q;
  logic [RW-1:0] i1_q, k1_q;
  // stage 2: products
  logic                     v2_q;
  logic [RW-1:0]            i2_q, k2_q;
  logic signed [W-1:0]      a_sel;
  logic signed [W-1:0]      b_w    [N];
  logic signed [PROD_W-1:0] prod_d [N];
  logic signed [PROD_W-1:0] prod_q [N];
  // stage 3: running sums
  logic                     done3_q;
  logic [RW-1:0]            i3_q;
  logic signed [ACC_W-1:0]  acc_d  [N];
  logic signed [ACC_W-1:0]  acc_q  [N];
  // stage 4: shift and saturate
  logic signed [ACC_W-1:0]  sh     [N];
  logic                     fits   [N];
  logic signed [W-1:0]      sat    [N];
  logic signed [mxm_pkg::DATA_W-1:0] c_w [N];
  mxm_pkg::out_t            out_d;

  // only the low word bits of each element are kept
  assign a_wdata = {in_i.a_col3[W-1:0], in_i.a_col2[W-1:0],
                    in_i.a_col1[W-1:0], in_i.a_col0[W-1:0]};
  assign b_wdata = {in_i.b_col3[W-1:0], in_i.b_col2[W-1:0],
                    in_i.b_col1[W-1:0], in_i.b_col0[W-1:0]};

  // A is read by product row, B by inner index
  mxm_ram #(
    .WIDTH(N * W),
    .DEPTH(N)
  ) u_a_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(cmd_i.wr_row),
    .wdata_i(a_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_i),
    .rdata_o(a_row)
  );

  mxm_ram #(
    .WIDTH(N * W),
    .DEPTH(N)
  ) u_b_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(cmd_i.wr_row),
    .wdata_i(b_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_k),
    .rdata_o(b_row)
  );

  assign a_sel = a_row[k1_q*W +: W];

  always_comb begin
    for (int j = 0; j < N; j++) begin
      b_w[j]    = b_row[j*W +: W];
      prod_d[j] = a_sel * b_w[j];
      acc_d[j]  = ((k2_q == '0) ? '0 : acc_q[j]) + ACC_W'(prod_q[j]);
      sh[j]     = acc_q[j] >>> FRAC_BITS;
      fits[j]   = (&sh[j][ACC_W-1:W-1]) || !(|sh[j][ACC_W-1:W-1]);
      sat[j]    = fits[j] ? sh[j][W-1:0] : (sh[j][ACC_W-1] ? MIN_V : MAX_V);
      c_w[j]    = mxm_pkg::DATA_W'(sat[j]);
    end
    out_d.c_col0     = c_w[0];
    out_d.c_col1     = c_w[1];
    out_d.c_col2     = c_w[2];
    out_d.c_col3     = c_w[3];
    out_d.row_number = i3_q;
    out_d.last_row   = (i3_q == LAST_IDX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      done3_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= cmd_i.rd_en;
      v2_q    <= v1_q;
      done3_q <= v2_q && (k2_q == LAST_IDX);
      valid_o <= done3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q <= cmd_i.rd_i;
    k1_q <= cmd_i.rd_k;
    i2_q <= i1_q;
    k2_q <= k1_q;
    if (v1_q) begin
      prod_q <= prod_d;
    end
    if (v2_q) begin
      acc_q <= acc_d;
      i3_q  <= i2_q;
    end
    if (done3_q) begin
      out_o <= out_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/matrix_multiply_4x4_top.sv =====
`default_nettype none
// Channel    Ports                          Transfer when
// ---------  -----------------------------  ------------------------------------
// row in     start_i, busy_o, in_i          start_i high and busy_o low
// result     result_valid_o, out_o          result_valid_o high (one cycle each)
//
// The fourth row transfer raises busy_o while four multipliers (one per result
// column) step the inner index k for each product row; busy_o stays high until all
// 16 (row, k) pairs are issued. Each product row passes the row store read, the
// product and the running-sum registers before out_o is registered, and the next
// matrix may load while those results still drain. Reset (rst_ni low, asynchronous)
// clears the row count and the pipeline valids; the row stores are not cleared.
// The receiver cannot stall results.
module matrix_multiply_4x4_top #(
  parameter int unsigned FRAC_BITS = mxm_pkg::FRAC_BITS_DF,
  parameter int unsigned WORD_BITS = mxm_pkg::WORD_BITS_DF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output      logic          busy_o,
  input  wire mxm_pkg::in_t  in_i,
  output      logic          result_valid_o,
  output      mxm_pkg::out_t out_o
);

  // command bundle from sequencer to datapath
  mxm_pkg::cmd_t cmd;

  // counts loaded rows, then walks the 16 (row, k) steps
  mxm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  // row stores, multipliers, accumulators, shift and saturate
  mxm_dp #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_i),
    .valid_o(result_valid_o),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

// ===== tb/mxm_result_checker.sv =====
`default_nettype none
// Watches both channels, keeps its own copy of the row stores and
// compares every product row against the oldest one outstanding.
module mxm_result_checker #(
  parameter int unsigned FRAC_BITS = mxm_pkg::FRAC_BITS_DF,
  parameter int unsigned WORD_BITS = mxm_pkg::WORD_BITS_DF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          busy_i,
  input  wire mxm_pkg::in_t  in_i,
  input  wire logic          result_valid_i,
  input  wire mxm_pkg::out_t out_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o,
  output int unsigned        rows_checked_o
);

  logic [31:0]   left_rows  [16];
  logic [31:0]   right_rows [16];
  logic [1:0]    loaded_rows = '0;
  mxm_pkg::out_t expected_rows [$];
  int unsigned   mismatches   = 0;
  int unsigned   rows_checked = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // low WORD_BITS bits, sign-extended
  function automatic longint widen(input logic [31:0] raw);
    longint v;
    v = longint'(raw);
    v = v <<< (64 - WORD_BITS);
    return v >>> (64 - WORD_BITS);
  endfunction

  function automatic logic [31:0] product_element(input int unsigned i, input int unsigned j);
    logic signed [67:0] acc;
    logic signed [67:0] top_val;
    logic signed [67:0] bot_val;
    longint             prod;
    acc = '0;
    for (int unsigned k = 0; k < 4; k++) begin
      prod = widen(left_rows[i*4 + k]) * widen(right_rows[k*4 + j]);
      acc  = acc + prod;
    end
    acc     = acc >>> FRAC_BITS;
    top_val = (68'sd1 <<< (WORD_BITS - 1)) - 68'sd1;
    bot_val = -(68'sd1 <<< (WORD_BITS - 1));
    if (acc > top_val) begin
      acc = top_val;
    end else if (acc < bot_val) begin
      acc = bot_val;
    end
    return acc[31:0];
  endfunction

  task automatic store_row(input mxm_pkg::in_t row);
    mxm_pkg::out_t prod;
    int unsigned   base;
    base = loaded_rows * 4;
    left_rows[base + 0]  = row.a_col0;
    left_rows[base + 1]  = row.a_col1;
    left_rows[base + 2]  = row.a_col2;
    left_rows[base + 3]  = row.a_col3;
    right_rows[base + 0] = row.b_col0;
    right_rows[base + 1] = row.b_col1;
    right_rows[base + 2] = row.b_col2;
    right_rows[base + 3] = row.b_col3;
    if (loaded_rows == 2'd3) begin
      for (int unsigned i = 0; i < 4; i++) begin
        prod.c_col0     = product_element(i, 0);
        prod.c_col1     = product_element(i, 1);
        prod.c_col2     = product_element(i, 2);
        prod.c_col3     = product_element(i, 3);
        prod.row_number = i[1:0];
        prod.last_row   = (i == 3);
        expected_rows.push_back(prod);
      end
    end
    loaded_rows = loaded_rows + 2'd1;
  endtask

  task automatic check_row(input mxm_pkg::out_t got);
    mxm_pkg::out_t want;
    logic [31:0]   got_c  [4];
    logic [31:0]   want_c [4];
    if (expected_rows.size() == 0) begin
      report_mismatch($sformatf("product row %0d with nothing outstanding", got.row_number));
      return;
    end
    want   = expected_rows.pop_front();
    got_c  = '{got.c_col0, got.c_col1, got.c_col2, got.c_col3};
    want_c = '{want.c_col0, want.c_col1, want.c_col2, want.c_col3};
    for (int unsigned j = 0; j < 4; j++) begin
      if (got_c[j] !== want_c[j]) begin
        report_mismatch($sformatf("row %0d c_col%0d got %h want %h",
                                  want.row_number, j, got_c[j], want_c[j]));
      end
    end
    if (got.row_number !== want.row_number) begin
      report_mismatch($sformatf("row_number got %0d want %0d", got.row_number,
                                want.row_number));
    end
    if (got.last_row !== want.last_row) begin
      report_mismatch($sformatf("row %0d last_row got %b want %b", want.row_number,
                                got.last_row, want.last_row));
    end
    rows_checked++;
  endtask

  // outputs move by nonblocking update so the stimulus side reads stable values
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_rows = '0;
      expected_rows.delete();
      mismatches_o   <= mismatches;
      pending_o      <= 0;
      rows_checked_o <= rows_checked;
    end else begin
      if (result_valid_i) check_row(out_i);
      if (start_i && !busy_i) store_row(in_i);
      mismatches_o   <= mismatches;
      pending_o      <= expected_rows.size();
      rows_checked_o <= rows_checked;
    end
  end

endmodule
`default_nettype wire

// ===== tb/matrix_multiply_4x4_top_tb.sv =====
`default_nettype none
// Stimulus and verdict for the 4x4 fixed-point matrix multiplier.
// The checker beside the block does all prediction and comparison.
module matrix_multiply_4x4_top_tb;

  localparam int unsigned FRAC_BITS   = mxm_pkg::FRAC_BITS_DF;
  localparam int unsigned WORD_BITS   = mxm_pkg::WORD_BITS_DF;
  // quiet cycles allowed before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 2000;
  // quiet tail kept after the last product row arrives
  localparam int unsigned DRAIN_CYCLES = 40;

  logic          clk_i   = 1'b0;
  logic          rst_ni  = 1'b0;
  logic          start_i = 1'b0;
  mxm_pkg::in_t  in_i    = '0;
  logic          busy_o;
  logic          result_valid_o;
  mxm_pkg::out_t out_o;

  int unsigned   mismatch_count;
  int unsigned   outstanding_rows;
  int unsigned   product_rows_seen;
  int unsigned   idle_pct   = 0;
  int unsigned   rows_sent  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  matrix_multiply_4x4_top #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .in_i          (in_i),
    .result_valid_o(result_valid_o),
    .out_o         (out_o)
  );

  mxm_result_checker #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .in_i          (in_i),
    .result_valid_i(result_valid_o),
    .out_i         (out_o),
    .mismatches_o  (mismatch_count),
    .pending_o     (outstanding_rows),
    .rows_checked_o(product_rows_seen)
  );

  // Word mix: extremes, small Q16.16 values (about +-4.0) that keep sums
  // out of saturation, and full 32-bit noise that mostly saturates.
  function automatic logic [31:0] pick_word();
    int unsigned sel;
    logic [31:0] w;
    sel = $urandom_range(99);
    if (sel < 15) begin
      case ($urandom_range(4))
        0:       w = 32'h0000_0000;
        1:       w = 32'h0000_0001;
        2:       w = 32'hFFFF_FFFF;
        3:       w = 32'h7FFF_FFFF;
        default: w = 32'h8000_0000;
      endcase
    end else if (sel < 65) begin
      w = $urandom_range(524287);
      w = w - 32'd262144;
    end else begin
      w = $urandom();
    end
    return w;
  endfunction

  function automatic mxm_pkg::in_t random_row();
    mxm_pkg::in_t row;
    row = '{pick_word(), pick_word(), pick_word(), pick_word(),
            pick_word(), pick_word(), pick_word(), pick_word()};
    return row;
  endfunction

  // One row transfer. Called at a rising edge; returns at the edge that
  // accepted the row. Idle cycles drop start_i and put junk on in_i, which
  // the block must ignore. Each path drives a signal once per edge.
  task automatic send_row(input mxm_pkg::in_t row);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      in_i    <= random_row();
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= row;
    // busy_o read here is the value before the edge: low means accepted
    do @(posedge clk_i); while (busy_o);
    rows_sent++;
  endtask

  // Whole matrix with every A element one value and every B element another
  task automatic send_fill(input logic [31:0] a_word, input logic [31:0] b_word);
    mxm_pkg::in_t row;
    row = '{a_word, a_word, a_word, a_word, b_word, b_word, b_word, b_word};
    repeat (4) send_row(row);
  endtask

  task automatic send_random_matrices(input int unsigned count);
    repeat (count * 4) send_row(random_row());
  endtask

  // Hang detector: counts edges with neither a row transfer nor a result.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || result_valid_o) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no transfer for %0d cycles, %0d product rows outstanding",
             QUIET_LIMIT, outstanding_rows);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    mxm_pkg::in_t row;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 1: sender idles in about a fifth of the cycles.
    idle_pct = 22;

    // Directed matrices first.
    // positive overflow: max * max saturates to the largest word
    send_fill(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // min * min is a large positive product, saturates high
    send_fill(32'h8000_0000, 32'h8000_0000);
    // max * min saturates to the smallest word
    send_fill(32'h7FFF_FFFF, 32'h8000_0000);
    // all zero
    send_fill(32'h0000_0000, 32'h0000_0000);
    // tiny negative sum: truncation rounds toward minus infinity, giving -1 lsb
    send_fill(32'hFFFF_FFFF, 32'h0000_0001);
    // identity (1.0 on the diagonal) times random B passes B through
    for (int unsigned k = 0; k < 4; k++) begin
      row        = random_row();
      row.a_col0 = (k == 0) ? 32'h0001_0000 : 32'h0;
      row.a_col1 = (k == 1) ? 32'h0001_0000 : 32'h0;
      row.a_col2 = (k == 2) ? 32'h0001_0000 : 32'h0;
      row.a_col3 = (k == 3) ? 32'h0001_0000 : 32'h0;
      send_row(row);
    end

    send_random_matrices(22);

    // Phase 2: sender idles most of the time.
    idle_pct = 63;
    send_random_matrices(21);

    // Phase 3: back-to-back, rows wait only on busy_o.
    idle_pct = 0;
    send_random_matrices(21);

    start_i <= 1'b0;

    // let every product row arrive, then a quiet tail for strays
    do @(posedge clk_i); while (outstanding_rows != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d row transfers (%0d matrices), checked %0d product rows",
             rows_sent, rows_sent / 4, product_rows_seen);
    $display("Covered saturation both ways, truncation, identity and random Q16.16 data");
    if (mismatch_count == 0 && outstanding_rows == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d product rows never arrived", mismatch_count,
               outstanding_rows);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/mxm_pkg.sv
rtl/core/mxm_ram.sv
rtl/core/mxm_ctrl.sv
rtl/core/mxm_dp.sv
rtl/core/matrix_multiply_4x4_top.sv
tb/mxm_result_checker.sv
tb/matrix_multiply_4x4_top_tb.sv
